// ----- rtl/at_command_framer_classifier_defines.svh -----
// ---------------------------------------------------------------------------
// AT command framer and classifier: assertion macros
// Shared checks on the block clock with reset held off.
// ---------------------------------------------------------------------------
`ifndef AT_COMMAND_FRAMER_CLASSIFIER_DEFINES_SVH
`define AT_COMMAND_FRAMER_CLASSIFIER_DEFINES_SVH

// Same-cycle implication
`define ATCF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ATCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/atcf_pkg.sv -----
// ---------------------------------------------------------------------------
// AT command framer and classifier: package
// Item types, command codes, templates and character helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package atcf_pkg;

    // Frame limits
    localparam int MAX_COMMAND_BYTES   = 64;
    localparam int COMMANDS_PER_BUFFER = 16;

    // Frame length saturates well above any legal maximum
    localparam int          LEN_W   = 9;
    localparam logic [8:0]  LEN_CAP = 9'h1FF;
    localparam int          ACC_W   = $clog2(COMMANDS_PER_BUFFER + 1);

    // Template lengths and argument positions
    localparam int QUERY_LEN       = 12;
    localparam int CONNECT_PREFIX  = 10;
    localparam int INTERVAL_PREFIX = 7;
    localparam int HEX_DIGITS      = 12;
    localparam int DEC_DIGITS      = 9;
    localparam int CONNECT_MIN_LEN = CONNECT_PREFIX + HEX_DIGITS + 2;

    localparam int HEX_W = 48;
    localparam int DEC_W = 30;

    // Template match bits
    localparam int TM_QUERY    = 0;
    localparam int TM_CONNECT  = 1;
    localparam int TM_INTERVAL = 2;

    // Characters
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_T    = 8'h54;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;

    // "AT+LESCAN?" CR LF
    localparam logic [7:0] TPL_QUERY [0:11] = '{
        8'h41, 8'h54, 8'h2B, 8'h4C, 8'h45, 8'h53,
        8'h43, 8'h41, 8'h4E, 8'h3F, 8'h0D, 8'h0A
    };
    // "AT+LESCAN="
    localparam logic [7:0] TPL_CONNECT [0:9] = '{
        8'h41, 8'h54, 8'h2B, 8'h4C, 8'h45, 8'h53,
        8'h43, 8'h41, 8'h4E, 8'h3D
    };
    // "AT+CIT="
    localparam logic [7:0] TPL_INTERVAL [0:6] = '{
        8'h41, 8'h54, 8'h2B, 8'h43, 8'h49, 8'h54, 8'h3D
    };

    typedef enum logic [1:0] {
        KIND_QUERY    = 2'd0,
        KIND_CONNECT  = 2'd1,
        KIND_INTERVAL = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_last;
    } byte_item_t;

    typedef struct packed {
        cmd_kind_t          command_kind;
        logic [HEX_W-1:0]   mac_address;
        logic [DEC_W-1:0]   interval_units;
    } cmd_item_t;

    // Outcome of one processed byte
    typedef struct packed {
        logic      hit;
        cmd_item_t item;
    } step_result_t;

    // Hex character to {valid, nibble}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (c inside {[8'h30:8'h39]}) begin
            t = c - 8'h30;
            return {1'b1, t[3:0]};
        end
        if (c inside {[8'h41:8'h46]}) begin
            t = c - 8'h37;
            return {1'b1, t[3:0]};
        end
        if (c inside {[8'h61:8'h66]}) begin
            t = c - 8'h57;
            return {1'b1, t[3:0]};
        end
        return 5'b0_0000;
    endfunction

    // Decimal character to {valid, digit}
    function automatic logic [4:0] dec_digit(input logic [7:0] c);
        logic [7:0] t;
        t = c - 8'h30;
        if (c inside {[8'h30:8'h39]}) begin
            return {1'b1, t[3:0]};
        end
        return 5'b0_0000;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/atcf_input_reg.sv -----
// ---------------------------------------------------------------------------
// AT command framer and classifier: input register
// Holds one received byte item until the core can process it.
// ---------------------------------------------------------------------------
`default_nettype none

module atcf_input_reg
    import atcf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    output logic            byte_stall,
    input  wire byte_item_t byte_item,
    input  wire logic       load_ok,
    output logic            s1_valid,
    output byte_item_t      s1_item
);

    logic       s1_valid_reg;
    logic       s1_valid_next;
    byte_item_t s1_item_reg;
    logic       accept;

    // Stall only while a held item cannot move on
    assign byte_stall = s1_valid_reg && !load_ok;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (load_ok)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= byte_item;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_item  = s1_item_reg;

endmodule

`default_nettype wire

// ----- rtl/atcf_core.sv -----
// ---------------------------------------------------------------------------
// AT command framer and classifier: framing and classification core
// Frame search, template matching, argument accumulation and result
// decision for one byte per enabled cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module atcf_core
    import atcf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step_en,
    input  wire byte_item_t s1_item,
    output step_result_t    step_out
);

    logic [7:0]       older_byte_reg, older_byte_next;
    logic [7:0]       newer_byte_reg, newer_byte_next;
    logic [1:0]       bytes_seen_reg, bytes_seen_next;
    logic             in_frame_reg, in_frame_next;
    logic [LEN_W-1:0] frame_length_reg, frame_length_next;
    logic [ACC_W-1:0] accepted_count_reg, accepted_count_next;
    logic [2:0]       template_match_reg, template_match_next;
    logic [HEX_W-1:0] hex_acc_reg, hex_acc_next;
    logic [DEC_W-1:0] dec_acc_reg, dec_acc_next;
    logic             digits_stopped_reg, digits_stopped_next;

    logic [7:0]       c;
    logic [LEN_W-1:0] p;
    logic [4:0]       hx;
    logic [4:0]       dd;
    logic [DEC_W+2:0] scaled;
    step_result_t     res;

    assign c  = s1_item.data_byte;
    assign p  = frame_length_reg;
    assign hx = hex_digit(c);
    assign dd = dec_digit(c);

    // floor(value * 5 / 8)
    assign scaled = ({3'b000, dec_acc_reg} << 2) + {3'b000, dec_acc_reg};

    // Next state and result for the byte in the input register
    always_comb
    begin
        older_byte_next     = older_byte_reg;
        newer_byte_next     = newer_byte_reg;
        bytes_seen_next     = bytes_seen_reg;
        in_frame_next       = in_frame_reg;
        frame_length_next   = frame_length_reg;
        accepted_count_next = accepted_count_reg;
        template_match_next = template_match_reg;
        hex_acc_next        = hex_acc_reg;
        dec_acc_next        = dec_acc_reg;
        digits_stopped_next = digits_stopped_reg;
        res                 = '0;

        if (!in_frame_reg)
        begin
            // Look for "AT+" inside the current buffer
            if (bytes_seen_reg == 2'd2 && older_byte_reg == CH_A &&
                newer_byte_reg == CH_T && c == CH_PLUS)
            begin
                in_frame_next       = 1'b1;
                frame_length_next   = LEN_W'(3);
                template_match_next = 3'b111;
                hex_acc_next        = '0;
                dec_acc_next        = '0;
                digits_stopped_next = 1'b0;
            end
        end
        else
        begin
            // Template comparison at this position
            if (p < LEN_W'(QUERY_LEN) && c != TPL_QUERY[p[3:0]])
            begin
                template_match_next[TM_QUERY] = 1'b0;
            end
            if (p < LEN_W'(CONNECT_PREFIX) && c != TPL_CONNECT[p[3:0]])
            begin
                template_match_next[TM_CONNECT] = 1'b0;
            end
            if (p < LEN_W'(INTERVAL_PREFIX) && c != TPL_INTERVAL[p[2:0]])
            begin
                template_match_next[TM_INTERVAL] = 1'b0;
            end

            // Argument digits
            if (template_match_next[TM_CONNECT])
            begin
                if (p >= LEN_W'(CONNECT_PREFIX) &&
                    p < LEN_W'(CONNECT_PREFIX + HEX_DIGITS))
                begin
                    if (!hx[4])
                    begin
                        digits_stopped_next = 1'b1;
                    end
                    else
                    begin
                        hex_acc_next = {hex_acc_reg[HEX_W-5:0], hx[3:0]};
                    end
                end
            end
            else if (template_match_next[TM_INTERVAL])
            begin
                if (p >= LEN_W'(INTERVAL_PREFIX) &&
                    p < LEN_W'(INTERVAL_PREFIX + DEC_DIGITS) && !digits_stopped_reg)
                begin
                    if (dd[4])
                    begin
                        dec_acc_next = (dec_acc_reg << 3) + (dec_acc_reg << 1) +
                                       DEC_W'(dd[3:0]);
                    end
                    else
                    begin
                        digits_stopped_next = 1'b1;
                    end
                end
            end

            if (frame_length_reg != LEN_CAP)
            begin
                frame_length_next = frame_length_reg + LEN_W'(1);
            end

            // CR LF closes the frame
            if (newer_byte_reg == CH_CR && c == CH_LF)
            begin
                in_frame_next = 1'b0;
                if (accepted_count_reg < ACC_W'(COMMANDS_PER_BUFFER) &&
                    frame_length_next <= LEN_W'(MAX_COMMAND_BYTES))
                begin
                    accepted_count_next = accepted_count_reg + ACC_W'(1);
                    if (template_match_next[TM_QUERY] &&
                        frame_length_next == LEN_W'(QUERY_LEN))
                    begin
                        res.hit               = 1'b1;
                        res.item.command_kind = KIND_QUERY;
                    end
                    else if (template_match_next[TM_CONNECT] &&
                             frame_length_next >= LEN_W'(CONNECT_MIN_LEN) &&
                             !digits_stopped_next)
                    begin
                        res.hit               = 1'b1;
                        res.item.command_kind = KIND_CONNECT;
                        res.item.mac_address  = hex_acc_next;
                    end
                    else if (template_match_next[TM_INTERVAL])
                    begin
                        res.hit                 = 1'b1;
                        res.item.command_kind   = KIND_INTERVAL;
                        res.item.interval_units = scaled[DEC_W+2:3];
                    end
                end
                frame_length_next   = '0;
                template_match_next = 3'b111;
                hex_acc_next        = '0;
                dec_acc_next        = '0;
                digits_stopped_next = 1'b0;
            end
        end

        // Byte history
        older_byte_next = newer_byte_reg;
        newer_byte_next = c;
        if (bytes_seen_reg != 2'd2)
        begin
            bytes_seen_next = bytes_seen_reg + 2'd1;
        end

        // End of receive buffer clears everything
        if (s1_item.buffer_last)
        begin
            older_byte_next     = '0;
            newer_byte_next     = '0;
            bytes_seen_next     = '0;
            in_frame_next       = 1'b0;
            frame_length_next   = '0;
            accepted_count_next = '0;
            template_match_next = 3'b111;
            hex_acc_next        = '0;
            dec_acc_next        = '0;
            digits_stopped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_byte_reg     <= '0;
            newer_byte_reg     <= '0;
            bytes_seen_reg     <= '0;
            in_frame_reg       <= 1'b0;
            frame_length_reg   <= '0;
            accepted_count_reg <= '0;
            template_match_reg <= 3'b111;
            hex_acc_reg        <= '0;
            dec_acc_reg        <= '0;
            digits_stopped_reg <= 1'b0;
        end
        else if (step_en)
        begin
            older_byte_reg     <= older_byte_next;
            newer_byte_reg     <= newer_byte_next;
            bytes_seen_reg     <= bytes_seen_next;
            in_frame_reg       <= in_frame_next;
            frame_length_reg   <= frame_length_next;
            accepted_count_reg <= accepted_count_next;
            template_match_reg <= template_match_next;
            hex_acc_reg        <= hex_acc_next;
            dec_acc_reg        <= dec_acc_next;
            digits_stopped_reg <= digits_stopped_next;
        end
    end

    assign step_out = res;

endmodule

`default_nettype wire

// ----- rtl/atcf_result_reg.sv -----
// ---------------------------------------------------------------------------
// AT command framer and classifier: result register
// Holds one command item until the consumer takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module atcf_result_reg
    import atcf_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step_en,
    input  wire step_result_t step_out,
    output logic              load_ok,
    output logic              cmd_valid,
    input  wire logic         cmd_stall,
    output cmd_item_t         cmd_item
);

    logic      cmd_valid_reg;
    logic      cmd_valid_next;
    cmd_item_t cmd_item_reg;

    // Free, or being emptied this cycle
    assign load_ok = !cmd_valid_reg || !cmd_stall;

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        if (load_ok)
        begin
            cmd_valid_next = step_en && step_out.hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ok && step_en && step_out.hit)
        begin
            cmd_item_reg <= step_out.item;
        end
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd_item  = cmd_item_reg;

endmodule

`default_nettype wire

// ----- rtl/at_command_framer_classifier.sv -----
// ---------------------------------------------------------------------------
// AT command framer and classifier: top level
// Frames "AT+" ... CR LF commands from a UART byte stream and reports
// scan queries, connect requests with a MAC, and connection intervals.
// ---------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  byte     | byte_valid / byte_stall | byte_item  (data_byte, buffer_last)
//  cmd      | cmd_valid  / cmd_stall  | cmd_item   (kind, mac, interval)
//
//  One byte item per cycle while byte_stall is low; a result passes
//  through the input register and then the result register.
//  No clearing pass after reset; the block takes items at once.
//  A stall on cmd only holds the byte channel once the result register
//  is full and the input register holds a waiting byte.
// ---------------------------------------------------------------------------
`default_nettype none

`include "at_command_framer_classifier_defines.svh"

module at_command_framer_classifier
    import atcf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    output logic            byte_stall,
    input  wire byte_item_t byte_item,
    output logic            cmd_valid,
    input  wire logic       cmd_stall,
    output cmd_item_t       cmd_item
);

    logic         load_ok;
    logic         s1_valid;
    byte_item_t   s1_item;
    logic         step_en;
    step_result_t step_out;

    // Byte processed when the result side can take its outcome
    assign step_en = s1_valid && load_ok;

    atcf_input_reg u_input_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .load_ok    (load_ok),
        .s1_valid   (s1_valid),
        .s1_item    (s1_item)
    );

    atcf_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_en  (step_en),
        .s1_item  (s1_item),
        .step_out (step_out)
    );

    atcf_result_reg u_result_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .step_out  (step_out),
        .load_ok   (load_ok),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item)
    );

    // Checks
    `ATCF_ASSERT_IMP(a_stall_needs_full_output, byte_stall, cmd_valid && cmd_stall, "byte stall without a blocked result")
    `ATCF_ASSERT_NEXT(a_held_byte_kept, s1_valid && !load_ok, s1_valid, "held byte lost while blocked")
    `ATCF_ASSERT_IMP(a_query_empty_payload, cmd_valid && cmd_item.command_kind == KIND_QUERY, cmd_item.mac_address == '0 && cmd_item.interval_units == '0, "query carries payload")
    `ATCF_ASSERT_IMP(a_connect_no_interval, cmd_valid && cmd_item.command_kind == KIND_CONNECT, cmd_item.interval_units == '0, "connect carries interval")
    `ATCF_ASSERT_IMP(a_interval_no_mac, cmd_valid && cmd_item.command_kind == KIND_INTERVAL, cmd_item.mac_address == '0, "interval carries mac")

endmodule

`default_nettype wire

// ----- verif/at_command_framer_classifier_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// AT command framer and classifier: testbench
// Streams UART bytes into the framer and checks every command it reports
// against a cycle-free model of the framing and classification rules. The run
// covers the command set, frame and buffer limits, a long result hold-off and
// random traffic with and without idling on both channels.
// ---------------------------------------------------------------------------
module at_command_framer_classifier_tb;
    import atcf_pkg::*;

    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          SETTLE_CYCLES  = 6;
    localparam int          MAX_REPORTS    = 10;
    localparam int          HOLD_CYCLES    = 300;
    localparam int unsigned LENGTH_CAP     = 65535;

    localparam logic [7:0] DIGIT_0 = 8'h30;
    localparam logic [7:0] DIGIT_9 = 8'h39;
    localparam logic [7:0] UPPER_A = 8'h41;
    localparam logic [7:0] UPPER_F = 8'h46;
    localparam logic [7:0] LOWER_A = 8'h61;
    localparam logic [7:0] LOWER_F = 8'h66;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    logic       clk;
    logic       rst_n;
    logic       byte_valid;
    logic       byte_stall;
    byte_item_t byte_item;
    logic       cmd_valid;
    logic       cmd_stall;
    cmd_item_t  cmd_item;

    at_command_framer_classifier dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_item   (cmd_item)
    );

    // Framer model state
    logic [7:0]  prev2_char;
    logic [7:0]  prev1_char;
    int          window_fill;
    bit          in_command;
    int unsigned frame_len;
    int          frames_taken;
    logic [2:0]  pattern_ok;
    logic [47:0] mac_acc;
    logic [31:0] dec_acc;
    bit          arg_halted;

    // Expected commands, oldest first
    cmd_item_t   pending_commands[$];

    // Bytes waiting to be sent, with their end-of-buffer marks
    logic [7:0]  stim_bytes[$];
    bit          stim_last[$];

    bit          tx_idling;
    bit          rx_idling;
    bit          hold_request;
    int          mismatches;
    int          results_checked;
    int          bytes_sent;
    int          buffers_ended;
    int          results_predicted;
    int          kind_seen[3];
    int          quiet_cycles;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Frame-level state, cleared at every frame open and close
    function automatic void clear_frame_state();
        frame_len  = 0;
        pattern_ok = 3'b111;
        mac_acc    = '0;
        dec_acc    = '0;
        arg_halted = 1'b0;
    endfunction

    function automatic void reset_framer_state();
        prev2_char   = 8'h00;
        prev1_char   = 8'h00;
        window_fill  = 0;
        in_command   = 1'b0;
        frames_taken = 0;
        clear_frame_state();
    endfunction

    // One byte through the framer; returns 1 when a command is reported
    function automatic bit classify_byte(input logic [7:0] ch, input logic last,
                                         output cmd_item_t cmd);
        int unsigned pos;
        logic [7:0]  digit;
        logic [34:0] scaled;
        bit          found;
        found = 1'b0;
        cmd   = '0;
        if (!in_command)
        begin
            if (window_fill >= 2 && prev2_char == CH_A && prev1_char == CH_T && ch == CH_PLUS)
            begin
                in_command = 1'b1;
                clear_frame_state();
                frame_len = 3;
            end
        end
        else
        begin
            pos = frame_len;
            // template tracking
            if (pos < QUERY_LEN && ch != TPL_QUERY[pos]) pattern_ok[TM_QUERY] = 1'b0;
            if (pos < CONNECT_PREFIX && ch != TPL_CONNECT[pos]) pattern_ok[TM_CONNECT] = 1'b0;
            if (pos < INTERVAL_PREFIX && ch != TPL_INTERVAL[pos])
                pattern_ok[TM_INTERVAL] = 1'b0;

            // argument digits
            if (pattern_ok[TM_CONNECT])
            begin
                if (pos >= CONNECT_PREFIX && pos < CONNECT_PREFIX + HEX_DIGITS)
                begin
                    digit = 8'hFF;
                    if (ch >= DIGIT_0 && ch <= DIGIT_9) digit = ch - DIGIT_0;
                    else if (ch >= UPPER_A && ch <= UPPER_F) digit = ch - UPPER_A + 8'd10;
                    else if (ch >= LOWER_A && ch <= LOWER_F) digit = ch - LOWER_A + 8'd10;
                    if (digit == 8'hFF) arg_halted = 1'b1;
                    else mac_acc = {mac_acc[43:0], digit[3:0]};
                end
            end
            else if (pattern_ok[TM_INTERVAL])
            begin
                if (pos >= INTERVAL_PREFIX && pos < INTERVAL_PREFIX + DEC_DIGITS && !arg_halted)
                begin
                    if (ch >= DIGIT_0 && ch <= DIGIT_9) dec_acc = dec_acc * 10 + (ch - DIGIT_0);
                    else arg_halted = 1'b1;
                end
            end

            if (frame_len < LENGTH_CAP) frame_len++;

            // CR LF closes the frame
            if (prev1_char == CH_CR && ch == CH_LF)
            begin
                in_command = 1'b0;
                if (frames_taken < COMMANDS_PER_BUFFER && frame_len <= MAX_COMMAND_BYTES)
                begin
                    frames_taken++;
                    if (pattern_ok[TM_QUERY] && frame_len == QUERY_LEN)
                    begin
                        cmd.command_kind = KIND_QUERY;
                        found = 1'b1;
                    end
                    else if (pattern_ok[TM_CONNECT] && frame_len >= CONNECT_MIN_LEN &&
                             !arg_halted)
                    begin
                        cmd.command_kind = KIND_CONNECT;
                        cmd.mac_address  = mac_acc;
                        found = 1'b1;
                    end
                    else if (pattern_ok[TM_INTERVAL])
                    begin
                        scaled = {3'b000, dec_acc} * 35'd5;
                        cmd.command_kind   = KIND_INTERVAL;
                        cmd.interval_units = scaled[32:3];
                        found = 1'b1;
                    end
                end
                clear_frame_state();
            end
        end

        prev2_char = prev1_char;
        prev1_char = ch;
        if (window_fill < 2) window_fill++;
        if (last) reset_framer_state();
        return found;
    endfunction

    // Offer one byte until taken, then maybe idle
    task automatic send_byte(input logic [7:0] ch, input logic last);
        byte_item_t it;
        cmd_item_t  cmd;
        it.data_byte   = ch;
        it.buffer_last = last;
        byte_valid <= 1'b1;
        byte_item  <= it;
        @(posedge clk);
        while (byte_stall) @(posedge clk);
        bytes_sent++;
        if (last) buffers_ended++;
        if (classify_byte(ch, last, cmd))
        begin
            pending_commands.push_back(cmd);
            results_predicted++;
            kind_seen[cmd.command_kind]++;
        end
        if (tx_idling && $urandom_range(0, 5) == 0)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    function automatic void put_char(input logic [7:0] ch);
        stim_bytes.push_back(ch);
        stim_last.push_back(1'b0);
    endfunction

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_char(s[i]);
    endfunction

    function automatic void put_crlf();
        put_char(CH_CR);
        put_char(CH_LF);
    endfunction

    function automatic void end_buffer();
        if (stim_last.size() > 0) stim_last[stim_last.size() - 1] = 1'b1;
    endfunction

    task automatic flush_items();
        for (int i = 0; i < stim_bytes.size(); i++) send_byte(stim_bytes[i], stim_last[i]);
        stim_bytes.delete();
        stim_last.delete();
    endtask

    // One command in a buffer of its own
    task automatic send_frame(input string body);
        put_text(body);
        put_crlf();
        end_buffer();
        flush_items();
    endtask

    // Sender pause until every expected command is out
    task automatic wait_until_drained();
        byte_valid <= 1'b0;
        while (pending_commands.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Every command form and argument corner
    task automatic test_command_set();
        tx_idling = 1'b1;
        rx_idling = 1'b1;
        send_frame("AT+LESCAN?");
        send_frame("at+lescan?");
        send_frame("AT+LESCAN=FFFFFFFFFFFF");
        send_frame("AT+LESCAN=000000000000");
        send_frame("AT+LESCAN=a1B2c3D4e5F6");
        send_frame("AT+LESCAN=12345");
        send_frame("AT+LESCAN=12345G789ABC");
        send_frame("AT+LESCAN=0123456789abXYZ");
        send_frame("AT+CIT=999999999");
        send_frame("AT+CIT=1234567890");
        send_frame("AT+CIT=");
        send_frame("AT+CIT=-5");
        send_frame("AT+CIT= 5");
        send_frame("AT+CIT=8");
        send_frame("AT+FOO");
        send_frame("AT+AT+LESCAN?");
        // high and low byte values ahead of a frame in the same buffer
        put_char(8'hFF);
        put_char(8'h00);
        put_char(8'h80);
        send_frame("AT+CIT=40");
        wait_until_drained();
    endtask

    // Frame length, per-buffer count and buffer boundaries
    task automatic test_buffer_limits();
        int body_len[2];
        body_len = '{MAX_COMMAND_BYTES - 2, MAX_COMMAND_BYTES - 1};
        // exactly at the size limit and one over
        foreach (body_len[i])
        begin
            put_text("AT+CIT=12");
            repeat (body_len[i] - 9) put_char(CH_X);
            put_crlf();
            end_buffer();
        end
        flush_items();

        // "AT+" split over two buffers never opens a frame
        put_text("xA");
        end_buffer();
        put_text("T+LESCAN?");
        put_crlf();
        end_buffer();
        put_text("AT");
        end_buffer();
        put_text("+LESCAN?");
        put_crlf();
        end_buffer();

        // frame still open at buffer end, closing bytes in the next buffer
        put_text("AT+LESCAN?");
        put_char(CH_CR);
        end_buffer();
        put_char(CH_LF);
        put_text("AT+LESCAN?");
        put_crlf();
        end_buffer();
        flush_items();

        // unknown command counts towards the limit; the last query is dropped
        put_text("AT+NOP");
        put_crlf();
        repeat (COMMANDS_PER_BUFFER)
        begin
            put_text("AT+LESCAN?");
            put_crlf();
        end
        end_buffer();
        flush_items();
        send_frame("AT+LESCAN?");
        wait_until_drained();
    endtask

    // Receiver holds off while the sender keeps going
    task automatic test_backpressure();
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        hold_request = 1'b1;
        for (int i = 0; i < 6; i++)
        begin
            if (i % 2 == 0) send_frame("AT+LESCAN?");
            else send_frame("AT+CIT=1600");
        end
        wait_until_drained();
    endtask

    // One random stretch of traffic into the send queue
    task automatic build_random_stretch();
        int          pick;
        int          n;
        int          first;
        logic [47:0] mac;
        logic [3:0]  nib;
        logic [7:0]  lead[3];
        lead = '{CH_MINUS, CH_PLUS, CH_SPACE};
        pick = $urandom_range(0, 24);
        first = stim_bytes.size();
        if (pick == 0)
        begin
            // many short commands in one buffer, around the per-buffer limit
            n = $urandom_range(COMMANDS_PER_BUFFER - 2, COMMANDS_PER_BUFFER + 4);
            repeat (n)
            begin
                if ($urandom_range(0, 1)) put_text("AT+LESCAN?");
                else
                begin
                    put_text("AT+CIT=");
                    put_char(8'(DIGIT_0 + $urandom_range(0, 9)));
                end
                put_crlf();
            end
        end
        else
        begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4)) put_char(8'($urandom_range(0, 255)));
            first = stim_bytes.size();
            if (pick <= 4)
            begin
                put_text("AT+LESCAN?");
                put_crlf();
            end
            else if (pick <= 10)
            begin
                mac = 48'({$urandom, $urandom});
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 11) : HEX_DIGITS;
                put_text("AT+LESCAN=");
                for (int i = 0; i < n; i++)
                begin
                    nib = mac[47 - 4 * i -: 4];
                    if (nib < 4'd10) put_char(DIGIT_0 + nib);
                    else if ($urandom_range(0, 1)) put_char(UPPER_A + nib - 4'd10);
                    else put_char(LOWER_A + nib - 4'd10);
                end
                if ($urandom_range(0, 5) == 0)
                    repeat ($urandom_range(1, 5)) put_char(8'($urandom_range(8'h21, 8'h7E)));
                put_crlf();
            end
            else if (pick <= 16)
            begin
                put_text("AT+CIT=");
                if ($urandom_range(0, 5) == 0) put_char(lead[$urandom_range(0, 2)]);
                if ($urandom_range(0, 7) == 0) repeat (DEC_DIGITS) put_char(DIGIT_9);
                else
                    repeat ($urandom_range(0, 12))
                        put_char(8'(DIGIT_0 + $urandom_range(0, 9)));
                if ($urandom_range(0, 4) == 0)
                begin
                    put_char(CH_X);
                    repeat ($urandom_range(1, 4)) put_char(8'(DIGIT_0 + $urandom_range(0, 9)));
                end
                put_crlf();
            end
            else if (pick <= 18)
            begin
                put_text("AT+");
                repeat ($urandom_range(0, 8)) put_char(8'(UPPER_A + $urandom_range(0, 25)));
                put_crlf();
            end
            else if (pick <= 20)
            begin
                // lengths around the frame size limit
                n = $urandom_range(MAX_COMMAND_BYTES - 6, MAX_COMMAND_BYTES + 4);
                put_text("AT+CIT=42");
                repeat (n - 9) put_char(CH_X);
                put_crlf();
            end
            else if (pick <= 22)
            begin
                repeat ($urandom_range(1, 8)) put_char(8'($urandom_range(0, 255)));
            end
            else
            begin
                // unterminated frame or a lone CR
                if ($urandom_range(0, 1)) put_text("AT+LESCAN");
                else put_text("AT+");
                put_char(CH_CR);
                put_char(8'($urandom_range(0, 255)));
            end
            // occasional corruption of a frame body
            if (pick <= 20 && $urandom_range(0, 7) == 0 && stim_bytes.size() > first + 3)
                stim_bytes[$urandom_range(first + 3, stim_bytes.size() - 1)] =
                    8'($urandom_range(0, 255));
        end
        // buffer end after some stretches, now and then in the middle of one
        if ($urandom_range(0, 23) == 0 && stim_bytes.size() > first)
            stim_last[$urandom_range(first, stim_bytes.size() - 1)] = 1'b1;
        if ($urandom_range(0, 2) == 0) end_buffer();
    endtask

    task automatic test_random_traffic(input int target_bytes, input int target_results,
                                       input bit with_idling);
        int start_bytes;
        int start_results;
        tx_idling     = with_idling;
        rx_idling     = with_idling;
        start_bytes   = bytes_sent;
        start_results = results_predicted;
        while (bytes_sent - start_bytes < target_bytes ||
               results_predicted - start_results < target_results)
        begin
            build_random_stretch();
            flush_items();
        end
        wait_until_drained();
    endtask

    // ---------------------------------------------------------------------
    // Result side
    // ---------------------------------------------------------------------

    // Receiver: random stall bursts, and the long hold-off on request
    initial
    begin : result_receiver
        cmd_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                cmd_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                cmd_stall <= 1'b0;
                hold_request = 1'b0;
            end
            else if (rx_idling && $urandom_range(0, 5) == 0)
            begin
                cmd_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                cmd_stall <= 1'b0;
            end
        end
    end

    // Compare each command taken with the oldest expectation
    always @(posedge clk)
    begin : command_check
        cmd_item_t want;
        if (rst_n && cmd_valid && !cmd_stall)
        begin
            if (pending_commands.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected command: kind %0d mac %h interval %0d",
                             cmd_item.command_kind, cmd_item.mac_address,
                             cmd_item.interval_units);
            end
            else
            begin
                want = pending_commands.pop_front();
                results_checked++;
                if (cmd_item.command_kind !== want.command_kind ||
                    cmd_item.mac_address !== want.mac_address ||
                    cmd_item.interval_units !== want.interval_units)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("command %0d: expected kind %0d mac %h interval %0d, got kind %0d mac %h interval %0d",
                                 results_checked, want.command_kind, want.mac_address,
                                 want.interval_units, cmd_item.command_kind,
                                 cmd_item.mac_address, cmd_item.interval_units);
                end
            end
        end
    end

    // Watchdog on cycles with no item moving on either channel
    always @(posedge clk)
    begin
        if ((byte_valid && !byte_stall) || (cmd_valid && !cmd_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("at_command_framer_classifier verification failed");
            $finish;
        end
    end

    // Sequence
    initial
    begin
        rst_n        <= 1'b0;
        byte_valid   <= 1'b0;
        byte_item    <= '0;
        tx_idling    = 1'b0;
        rx_idling    = 1'b0;
        hold_request = 1'b0;
        quiet_cycles = 0;
        reset_framer_state();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_command_set();
        test_buffer_limits();
        test_backpressure();
        test_random_traffic(80, 5, 1'b1);
        // final stretch without idling on either side
        test_random_traffic(40, 3, 1'b0);

        $display("Sent %0d bytes in %0d buffers; %0d commands checked (%0d scan, %0d connect, %0d interval).",
                 bytes_sent, buffers_ended, results_checked,
                 kind_seen[KIND_QUERY], kind_seen[KIND_CONNECT], kind_seen[KIND_INTERVAL]);
        $display("Covered size and per-buffer limits, split starts, open frames, a long hold-off; %0d mismatches.",
                 mismatches);
        if (mismatches == 0 && pending_commands.size() == 0)
            $display("at_command_framer_classifier verification clean");
        else
            $display("at_command_framer_classifier verification failed");
        $finish;
    end

endmodule
